// ===== sv/four_digit_seven_segment_scanner_assert.svh =====
// Assertion macros shared by the scanner modules.
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// A condition that must hold at every clock edge out of reset.
`define FSSS_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A condition that must hold in the cycle after a trigger.
`define FSSS_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define FSSS_ASSERT(name, cond, msg)
`define FSSS_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

// ===== sv/fsss_pkg.sv =====
// Types, constants and helper functions of the four-digit seven-segment scanner.
package fsss_pkg;

    localparam int DIGIT_COUNT   = 4;
    localparam int FRACTION_BITS = 12;

    localparam int VALUE_W = 29;
    localparam int DEC_W   = 8;
    localparam int SEG_W   = 8;
    localparam int SCALE_W = 10;
    localparam int PROD_W  = VALUE_W + SCALE_W;
    localparam int NUM_W   = 14;
    localparam int REM_W   = 10;
    localparam int CODE_W  = 4;
    localparam int POINT_W = 3;
    localparam int SCAN_W  = $clog2(DIGIT_COUNT);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;
    localparam logic [CODE_W-1:0] CODE_E     = 4'd11;
    localparam logic [CODE_W-1:0] CODE_R     = 4'd12;
    localparam logic [CODE_W-1:0] CODE_BLANK = 4'd13;

    localparam logic [POINT_W-1:0] POINT_OFF = 3'd5;

    localparam int DISPLAY_MAX = 9999;
    localparam int NEG_MAX     = 999;

    localparam logic [PROD_W-1:0] LIM_POS = PROD_W'(DISPLAY_MAX) << FRACTION_BITS;
    localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(NEG_MAX) << FRACTION_BITS;

    typedef enum logic [1:0] {
        ACT_SHOW_INT = 2'd0,
        ACT_SHOW_FIX = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_IGNORE   = 2'd3
    } action_t;

    typedef enum logic {
        CMD_SHOW = 1'b0,
        CMD_TICK = 1'b1
    } cmd_op_t;

    // Product stage register of the front part.
    typedef struct packed {
        action_t           act;
        logic              neg;
        logic              dec_big;
        logic [1:0]        dec2;
        logic [PROD_W-1:0] prod;
    } s1_t;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        cmd_op_t            op;
        logic               err;
        logic               minus;
        logic [POINT_W-1:0] point;
        logic [CODE_W-1:0]  thousands;
        logic [REM_W-1:0]   rest;
    } cmd_t;

    typedef struct packed {
        logic [CODE_W-1:0] digit;
        logic [NUM_W-1:0]  rest;
    } split_t;

    // Active-high segment pattern, bit7 a down to bit1 g, bit0 unused.
    function automatic logic [SEG_W-1:0] lit_segments(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] pat;
        unique case (code)
            4'd0:    pat = 8'hFC;
            4'd1:    pat = 8'h60;
            4'd2:    pat = 8'hDA;
            4'd3:    pat = 8'hF2;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'hB6;
            4'd6:    pat = 8'hBE;
            4'd7:    pat = 8'hE0;
            4'd8:    pat = 8'hFE;
            4'd9:    pat = 8'hF6;
            4'd10:   pat = 8'h02;
            4'd11:   pat = 8'h9E;
            4'd12:   pat = 8'h0A;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

    // One decimal digit by parallel compares against the multiples of base.
    // The value must stay below ten times base.
    function automatic split_t digit_split(input logic [NUM_W-1:0] val,
                                           input logic [NUM_W-1:0] base);
        split_t res;
        res.digit = '0;
        res.rest  = val;
        for (int k = 1; k <= 9; k++) begin
            if (val >= NUM_W'(k) * base) begin
                res.digit = CODE_W'(k);
                res.rest  = val - NUM_W'(k) * base;
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/four_digit_seven_segment_scanner.sv =====
// Four-digit seven-segment scanner: top level joining front, request queue and back.
// Throughput: one request per cycle, show requests and ticks alike, while full is low.
// Path: a tick result passes the product register, the request queue and
// the output register to the result ports; it waits while results are not popped.
// A show request takes the same path but ends in the digit registers; later ticks see it.
// Reset: digits zero, point at digit 0, scan at digit 0, ticks ignored until the first show.
module four_digit_seven_segment_scanner
    import fsss_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                action,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [DEC_W-1:0]          decimals,
    output logic                      empty,
    input  logic                      pop,
    output logic [SEG_W-1:0]          segments_n,
    output logic [DIGIT_COUNT-1:0]    digit_enable_n,
    output logic [SCAN_W-1:0]         digit_index
);

    logic q_wr;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_wr_data;
    cmd_t q_rd_data;

    fsss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .action   (action),
        .value    (value),
        .decimals (decimals),
        .q_wr     (q_wr),
        .q_data   (q_wr_data),
        .q_full   (q_full)
    );

    fsss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd      (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    fsss_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .q_data         (q_rd_data),
        .empty          (empty),
        .pop            (pop),
        .segments_n     (segments_n),
        .digit_enable_n (digit_enable_n),
        .digit_index    (digit_index)
    );

endmodule

// ===== sv/fsss_front.sv =====
// Front part: accepts requests, scales the value and classifies the request.
module fsss_front
    import fsss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         action,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [DEC_W-1:0]   decimals,
    output logic               q_wr,
    output cmd_t               q_data,
    input  logic               q_full
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    s1_t                s1_reg;
    s1_t                s1_next;
    logic               accept;
    logic               s1_adv;
    logic [VALUE_W-1:0] mag;
    logic [SCALE_W-1:0] scale;
    logic [PROD_W-1:0]  int_part;
    logic [NUM_W-1:0]   num;
    split_t             th;

    assign s1_adv = !s1_valid_reg || q_wr;
    assign full   = !s1_adv;
    assign accept = push && s1_adv;
    assign q_wr   = s1_valid_reg && !q_full;

    // Magnitude times 10^(decimals mod 4) when fixed point, else times one.
    always_comb
    begin
        s1_next.act     = action_t'(action);
        s1_next.neg     = value[VALUE_W-1];
        s1_next.dec_big = |decimals[DEC_W-1:2];
        s1_next.dec2    = decimals[1:0];
        mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
        if (action_t'(action) == ACT_SHOW_FIX)
        begin
            case (decimals[1:0])
                2'd0:    scale = SCALE_W'(1);
                2'd1:    scale = SCALE_W'(10);
                2'd2:    scale = SCALE_W'(100);
                default: scale = SCALE_W'(1000);
            endcase
        end
        else
        begin
            scale = SCALE_W'(1);
        end
        s1_next.prod = PROD_W'(mag) * PROD_W'(scale);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = (action_t'(action) != ACT_IGNORE);
        else if (q_wr)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
    end

    // Checks with decimals are exact on the product, before truncation.
    always_comb
    begin
        int_part     = s1_reg.prod >> FRACTION_BITS;
        q_data.op    = CMD_SHOW;
        q_data.err   = 1'b0;
        q_data.minus = 1'b0;
        q_data.point = POINT_OFF;
        num          = int_part[NUM_W-1:0];
        unique case (s1_reg.act)
            ACT_SHOW_INT:
            begin
                q_data.err = s1_reg.neg || (s1_reg.prod > PROD_W'(DISPLAY_MAX));
                num        = s1_reg.prod[NUM_W-1:0];
            end
            ACT_SHOW_FIX:
            begin
                q_data.minus = s1_reg.neg;
                q_data.point = (s1_reg.dec2 == 2'd0) ? POINT_OFF
                             : POINT_W'(3) - POINT_W'(s1_reg.dec2);
                if (!s1_reg.neg)
                    q_data.err = s1_reg.dec_big
                               || ((s1_reg.dec2 != 2'd0) && (s1_reg.prod > LIM_POS))
                               || ((s1_reg.dec2 == 2'd0)
                                   && (int_part > PROD_W'(DISPLAY_MAX)));
                else
                    q_data.err = s1_reg.dec_big || (s1_reg.dec2 == 2'd3)
                               || ((s1_reg.dec2 != 2'd0) && (s1_reg.prod > LIM_NEG))
                               || ((s1_reg.dec2 == 2'd0) && (int_part > PROD_W'(NEG_MAX)));
            end
            ACT_TICK:
            begin
                q_data.op = CMD_TICK;
            end
            ACT_IGNORE:
            begin
                q_data.op = CMD_TICK;
            end
        endcase
        th               = digit_split(num, NUM_W'(1000));
        q_data.thousands = th.digit;
        q_data.rest      = th.rest[REM_W-1:0];
    end

endmodule

// ===== sv/fsss_queue.sv =====
// Short request queue between the front and back parts.
`include "four_digit_seven_segment_scanner_assert.svh"
module fsss_queue
    import fsss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd,
    output cmd_t rd_data,
    output logic empty
);

    cmd_t             entries_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full    = (cnt_reg == CNT_W'(Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr && !rd)
            cnt_next = cnt_reg + 1'b1;
        else if (rd && !wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

    `FSSS_ASSERT(a_no_overflow, !(wr && full), "write into a full request queue")
    `FSSS_ASSERT(a_no_underflow, !(rd && empty), "read from an empty request queue")
    `FSSS_ASSERT_NEXT(a_count_up, wr && !rd, cnt_reg == $past(cnt_reg) + 1'b1, "count missed a write")

endmodule

// ===== sv/fsss_back.sv =====
// Back part: holds the digit state, applies show requests and serves scan ticks.
`include "four_digit_seven_segment_scanner_assert.svh"
module fsss_back
    import fsss_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    output logic                    q_pop,
    input  cmd_t                    q_data,
    output logic                    empty,
    input  logic                    pop,
    output logic [SEG_W-1:0]        segments_n,
    output logic [DIGIT_COUNT-1:0]  digit_enable_n,
    output logic [SCAN_W-1:0]       digit_index
);

    logic [CODE_W-1:0]      codes_reg [DIGIT_COUNT];
    logic [CODE_W-1:0]      codes_next [DIGIT_COUNT];
    logic [POINT_W-1:0]     point_reg;
    logic [POINT_W-1:0]     point_next;
    logic [SCAN_W-1:0]      scan_reg;
    logic [SCAN_W-1:0]      scan_next;
    logic                   running_reg;
    logic                   running_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SEG_W-1:0]       seg_reg;
    logic [SEG_W-1:0]       seg_next;
    logic [DIGIT_COUNT-1:0] den_reg;
    logic [DIGIT_COUNT-1:0] den_next;
    logic [SCAN_W-1:0]      idx_reg;
    logic                   slot_free;
    logic                   emit;
    split_t                 hund;
    split_t                 tens;

    assign slot_free = !out_valid_reg || pop;
    // Once running, a tick waits only for the output slot; all else goes through.
    assign q_pop = !q_empty && ((q_data.op == CMD_SHOW) || !running_reg || slot_free);
    assign emit  = q_pop && (q_data.op == CMD_TICK) && running_reg;

    always_comb
    begin
        hund = digit_split(NUM_W'(q_data.rest), NUM_W'(100));
        tens = digit_split(hund.rest, NUM_W'(10));
    end

    always_comb
    begin
        codes_next   = codes_reg;
        point_next   = point_reg;
        scan_next    = scan_reg;
        running_next = running_reg;
        if (q_pop && (q_data.op == CMD_SHOW))
        begin
            running_next = 1'b1;
            if (q_data.err)
            begin
                codes_next[0] = CODE_BLANK;
                codes_next[1] = CODE_E;
                codes_next[2] = CODE_R;
                codes_next[3] = CODE_R;
                point_next    = POINT_OFF;
            end
            else
            begin
                codes_next[0] = q_data.minus ? CODE_MINUS : q_data.thousands;
                codes_next[1] = hund.digit;
                codes_next[2] = tens.digit;
                codes_next[3] = tens.rest[CODE_W-1:0];
                point_next    = q_data.point;
            end
        end
        if (emit)
            scan_next = scan_reg + 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        seg_next    = ~lit_segments(codes_reg[scan_reg]) & 8'hFE;
        seg_next[0] = ({1'b0, scan_reg} != point_reg);
        den_next    = ~(DIGIT_COUNT'(1) << scan_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
                codes_reg[i] <= '0;
            point_reg     <= '0;
            scan_reg      <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            codes_reg     <= codes_next;
            point_reg     <= point_next;
            scan_reg      <= scan_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            seg_reg <= seg_next;
            den_reg <= den_next;
            idx_reg <= scan_reg;
        end
    end

    assign empty          = !out_valid_reg;
    assign segments_n     = seg_reg;
    assign digit_enable_n = den_reg;
    assign digit_index    = idx_reg;

    `FSSS_ASSERT(a_enable_onecold, !out_valid_reg || $onehot(~den_reg), "digit enable not one-cold")
    `FSSS_ASSERT(a_enable_matches, !out_valid_reg || (den_reg == ~(DIGIT_COUNT'(1) << idx_reg)), "enable and index disagree")
    `FSSS_ASSERT(a_running_holds, !$fell(running_reg), "running dropped after start")
    `FSSS_ASSERT_NEXT(a_scan_steps, emit, scan_reg == $past(scan_reg) + 1'b1, "scan did not advance")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench of the four-digit seven-segment scanner.
`timescale 1ns / 1ps

module tb_top;
    import fsss_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 140;

    typedef struct {
        action_t                   act;
        logic signed [VALUE_W-1:0] val;
        logic [DEC_W-1:0]          dec;
    } display_req_t;

    typedef struct {
        logic [SEG_W-1:0]       seg;
        logic [DIGIT_COUNT-1:0] en;
        logic [SCAN_W-1:0]      idx;
    } scan_out_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;
    logic [DEC_W-1:0]          decimals;
    logic                      empty;
    logic                      pop;
    logic [SEG_W-1:0]          segments_n;
    logic [DIGIT_COUNT-1:0]    digit_enable_n;
    logic [SCAN_W-1:0]         digit_index;

    // Predicted display state.
    logic [CODE_W-1:0]  shown_codes [DIGIT_COUNT];
    logic [POINT_W-1:0] shown_point;
    logic [SCAN_W-1:0]  scan_pos;
    bit                 scan_running;

    scan_out_t pending_scans[$];

    int fail_count;
    int shows_taken;
    int ticks_taken;
    int others_taken;
    int scans_checked;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;

    four_digit_seven_segment_scanner i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .action         (action),
        .value          (value),
        .decimals       (decimals),
        .empty          (empty),
        .pop            (pop),
        .segments_n     (segments_n),
        .digit_enable_n (digit_enable_n),
        .digit_index    (digit_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [SEG_W-1:0] glyph_on(input logic [CODE_W-1:0] code);
        case (code)
            4'd0:       return 8'hFC;
            4'd1:       return 8'h60;
            4'd2:       return 8'hDA;
            4'd3:       return 8'hF2;
            4'd4:       return 8'h66;
            4'd5:       return 8'hB6;
            4'd6:       return 8'hBE;
            4'd7:       return 8'hE0;
            4'd8:       return 8'hFE;
            4'd9:       return 8'hF6;
            CODE_MINUS: return 8'h02;
            CODE_E:     return 8'h9E;
            CODE_R:     return 8'h0A;
            default:    return 8'h00;
        endcase
    endfunction

    function automatic void load_error();
        shown_codes[0] = CODE_BLANK;
        shown_codes[1] = CODE_E;
        shown_codes[2] = CODE_R;
        shown_codes[3] = CODE_R;
        shown_point    = POINT_OFF;
    endfunction

    function automatic void load_digits(input longint n, input bit minus);
        for (int i = DIGIT_COUNT - 1; i >= 0; i--)
        begin
            shown_codes[i] = CODE_W'(n % 10);
            n = n / 10;
        end
        if (minus)
            shown_codes[0] = CODE_MINUS;
    endfunction

    // Applies one request to the predicted state; returns 1 when it drives a digit.
    function automatic bit predict_scan(input display_req_t r, output scan_out_t res);
        longint v;
        longint one;
        longint mag;
        longint scale;
        bit     neg;
        bit     bad;
        v   = r.val;
        one = longint'(1) << FRACTION_BITS;
        res = '{default: '0};
        if (r.act == ACT_SHOW_INT)
        begin
            shown_point = POINT_OFF;
            if (v < 0 || v > DISPLAY_MAX)
                load_error();
            else
                load_digits(v, 1'b0);
            scan_running = 1'b1;
            return 1'b0;
        end
        if (r.act == ACT_SHOW_FIX)
        begin
            neg = v < 0;
            bad = 1'b0;
            // Range limits are checked exactly on the scaled value, before truncation.
            if (!neg)
            begin
                if (r.dec > 3)
                    bad = 1'b1;
                else if (r.dec == 3 && v * 1000 > DISPLAY_MAX * one)
                    bad = 1'b1;
                else if (r.dec == 2 && v * 100 > DISPLAY_MAX * one)
                    bad = 1'b1;
                else if (r.dec == 1 && v * 10 > DISPLAY_MAX * one)
                    bad = 1'b1;
            end
            else
            begin
                if (r.dec > 2)
                    bad = 1'b1;
                else if (r.dec == 2 && v * 100 < -NEG_MAX * one)
                    bad = 1'b1;
                else if (r.dec == 1 && v * 10 < -NEG_MAX * one)
                    bad = 1'b1;
            end
            if (bad)
                load_error();
            else
            begin
                mag   = neg ? -v : v;
                scale = (r.dec == 0) ? 1 : (r.dec == 1) ? 10 : (r.dec == 2) ? 100 : 1000;
                mag   = (mag * scale) >> FRACTION_BITS;
                if (mag > (neg ? NEG_MAX : DISPLAY_MAX))
                    load_error();
                else
                begin
                    shown_point = (r.dec == 0) ? POINT_OFF : POINT_W'(3 - r.dec);
                    load_digits(mag, neg);
                end
            end
            scan_running = 1'b1;
            return 1'b0;
        end
        if (r.act == ACT_TICK && scan_running)
        begin
            res.idx = scan_pos;
            res.seg = ~glyph_on(shown_codes[scan_pos]) & 8'hFE;
            if (POINT_W'(scan_pos) != shown_point)
                res.seg[0] = 1'b1;
            res.en   = ~(4'b0001 << scan_pos);
            scan_pos = scan_pos + 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic display_req_t make_req(input action_t act, input int val,
                                              input int dec);
        display_req_t r;
        r.act = act;
        r.val = VALUE_W'(val);
        r.dec = DEC_W'(dec);
        return r;
    endfunction

    // Ticks carry random payload, which the block must ignore.
    function automatic display_req_t tick_req();
        return make_req(ACT_TICK, $urandom(), $urandom_range(255));
    endfunction

    function automatic display_req_t random_request();
        display_req_t r;
        int           pick;
        int           mag;
        pick  = $urandom_range(99);
        r     = tick_req();
        if (pick < 4)
            r.act = ACT_IGNORE;
        else if (pick < 20)
        begin
            r.act = ACT_SHOW_INT;
            pick  = $urandom_range(99);
            if (pick < 70)
                r.val = VALUE_W'($urandom_range(DISPLAY_MAX + 100));
            else if (pick < 85)
                r.val = VALUE_W'($urandom_range(DISPLAY_MAX + 3, DISPLAY_MAX - 3));
            else
                r.val = VALUE_W'($urandom());
        end
        else if (pick < 40)
        begin
            r.act = ACT_SHOW_FIX;
            r.dec = ($urandom_range(99) < 85) ? DEC_W'($urandom_range(3))
                                               : DEC_W'($urandom_range(255));
            if ($urandom_range(99) < 90)
            begin
                // Magnitudes spread over each decade so every limit is approached.
                case ($urandom_range(3))
                    0:       mag = $urandom_range(11 << FRACTION_BITS);
                    1:       mag = $urandom_range(101 << FRACTION_BITS);
                    2:       mag = $urandom_range(1001 << FRACTION_BITS);
                    default: mag = $urandom_range(10001 << FRACTION_BITS);
                endcase
                r.val = VALUE_W'(($urandom_range(99) < 40) ? -mag : mag);
            end
            else
                r.val = VALUE_W'($urandom());
        end
        return r;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic send_request(input display_req_t r);
        scan_out_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        action   <= r.act;
        value    <= r.val;
        decimals <= r.dec;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (predict_scan(r, res))
            pending_scans.push_back(res);
        if (r.act == ACT_TICK)
            ticks_taken++;
        else if (r.act == ACT_IGNORE)
            others_taken++;
        else
            shows_taken++;
    endtask

    task automatic end_requests();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_results_done();
        while (pending_scans.size() != 0)
            @(posedge clk);
    endtask

    task automatic show_and_scan(input display_req_t r, input int ticks);
        send_request(r);
        repeat (ticks) send_request(tick_req());
    endtask

    task automatic test_idle_before_start();
        send_request(tick_req());
        send_request(make_req(ACT_IGNORE, $urandom(), $urandom_range(255)));
    endtask

    task automatic test_basic_shows();
        show_and_scan(make_req(ACT_SHOW_INT, 1234, 0), 4);
        // Minus one and a half with one decimal reads as -015 with the point on digit 2.
        show_and_scan(make_req(ACT_SHOW_FIX, -6144, 1), 4);
        // Just under the three-decimal limit.
        show_and_scan(make_req(ACT_SHOW_FIX, 40955, 3), 4);
    endtask

    task automatic test_out_of_range();
        show_and_scan(make_req(ACT_SHOW_INT, 9999, 0), 1);
        show_and_scan(make_req(ACT_SHOW_INT, 268435455, 0), 1);
        show_and_scan(make_req(ACT_SHOW_FIX, 4096, 2), 1);
        show_and_scan(make_req(ACT_SHOW_INT, -268435456, 0), 1);
        show_and_scan(make_req(ACT_SHOW_FIX, 40956, 3), 1);
        show_and_scan(make_req(ACT_SHOW_FIX, -4096, 3), 1);
        // A negative whole number above 999 is an error rather than clipped.
        show_and_scan(make_req(ACT_SHOW_FIX, -4096000, 0), 1);
        show_and_scan(make_req(ACT_SHOW_FIX, 0, 255), 1);
    endtask

    task automatic test_output_stall();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_requests++;
        repeat (24) send_request(tick_req());
        send_idle_pct = saved_pct;
        end_requests();
        wait_results_done();
    endtask

    task automatic test_sender_pause();
        repeat (12) send_request(random_request());
        end_requests();
        wait_results_done();
        repeat ($urandom_range(3, 12)) @(posedge clk);
        repeat (12) send_request(random_request());
    endtask

    task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (items) send_request(random_request());
    endtask

    // Result checker and receiver side of the handshake.
    always @(posedge clk)
    begin
        scan_out_t exp;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (pending_scans.size() == 0)
                    report_failure($sformatf("unexpected result seg=%h en=%h idx=%0d",
                                             segments_n, digit_enable_n, digit_index));
                else
                begin
                    exp = pending_scans.pop_front();
                    scans_checked++;
                    if (segments_n !== exp.seg || digit_enable_n !== exp.en ||
                        digit_index !== exp.idx)
                        report_failure($sformatf(
                            "mismatch: expected seg=%h en=%h idx=%0d, got seg=%h en=%h idx=%0d",
                            exp.seg, exp.en, exp.idx, segments_n, digit_enable_n,
                            digit_index));
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        action        = ACT_SHOW_INT;
        value         = '0;
        decimals      = '0;
        fail_count    = 0;
        shows_taken   = 0;
        ticks_taken   = 0;
        others_taken  = 0;
        scans_checked = 0;
        cycle_count   = 0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        send_idle_pct = 29;
        recv_idle_pct = 81;
        for (int i = 0; i < DIGIT_COUNT; i++)
            shown_codes[i] = '0;
        shown_point  = '0;
        scan_pos     = '0;
        scan_running = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_before_start();
        test_basic_shows();
        test_out_of_range();
        test_output_stall();
        test_random_traffic(PHASE_ITEMS, 29, 81);
        test_sender_pause();
        test_random_traffic(PHASE_ITEMS, 81, 29);
        test_random_traffic(PHASE_ITEMS, 0, 0);
        end_requests();

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_scans.size() != 0)
            report_failure($sformatf("%0d expected results never arrived",
                                     pending_scans.size()));

        $display("Requests taken: %0d shows, %0d ticks, %0d unused codes.",
                 shows_taken, ticks_taken, others_taken);
        $display("Scan results checked: %0d, failures: %0d.", scans_checked, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
